// ===== rtl/core/spq_pkg.sv =====
// Shared types, codes and constants for the stable priority queue with undo.
`default_nettype none
package spq_pkg;
	localparam int QueueDepthDef   = 64;
	localparam int HistoryDepthDef = 16;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SERVE  = 2'd1;
	localparam logic [1:0] OP_UNDO   = 2'd2;
	localparam logic [1:0] OP_SEARCH = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_INVALID  = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_NOHIST   = 3'd4;
	localparam logic [2:0] ST_NOTFOUND = 3'd5;

	localparam logic [7:0]  AGE_MIN = 8'd1;
	localparam logic [7:0]  AGE_MAX = 8'd150;
	localparam logic [1:0]  PRIO_BEST = 2'd1;
	localparam logic [1:0]  PRIO_WORST = 2'd3;
	localparam logic [15:0] CNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  age;
		logic [1:0]  prio;
	} entry_t;

	// classified command handed from front to back
	typedef struct packed {
		logic [1:0]  op;
		logic        bad;   // insert fields out of range
		entry_t      ent;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		entry_t      ent;
		logic [15:0] registered;
		logic [15:0] served;
		logic [15:0] undone;
		logic [6:0]  waiting;
	} rsp_t;
endpackage
`default_nettype wire

// ===== rtl/core/spq_if.sv =====
// Valid/ready channel interfaces for commands and results.
`default_nettype none
interface spq_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [15:0] patient_id;
	logic [7:0]  patient_age;
	logic [1:0]  priority_level;
	modport source (output valid, operation, patient_id, patient_age, priority_level,
		input ready);
	modport sink (input valid, operation, patient_id, patient_age, priority_level,
		output ready);
endinterface

interface spq_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] entry_id;
	logic [7:0]  entry_age;
	logic [1:0]  entry_priority;
	logic [15:0] registered_count;
	logic [15:0] served_count;
	logic [15:0] undone_count;
	logic [6:0]  waiting_count;
	modport source (output valid, status, entry_id, entry_age, entry_priority,
		registered_count, served_count, undone_count, waiting_count, input ready);
	modport sink (input valid, status, entry_id, entry_age, entry_priority,
		registered_count, served_count, undone_count, waiting_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/stable_priority_queue_with_undo_top.sv =====
// Top level of the stable three-level priority queue with serve history and undo.
// channel | dir | transaction
// cmd     | in  | operation, patient_id, patient_age, priority_level
// rsp     | out | status, entry fields, four counters
// From cmd transaction to rsp valid: front queue, EXEC, SRV (serve) or UND (undo), DONE;
// a search loops SCAN then SCHK, one queued entry per pass (registered memory read).
// The back end takes the next command the cycle after the result transaction.
// Reset clears counts and pointers; stores need no clearing.
// Up to two commands wait in the front queue while the back end or rsp stalls.
`default_nettype none
module stable_priority_queue_with_undo_top import spq_pkg::*; #(
	parameter int QUEUE_DEPTH   = QueueDepthDef,
	parameter int HISTORY_DEPTH = HistoryDepthDef
) (
	input  wire logic clk,
	input  wire logic arst_n,
	spq_cmd_if.sink   cmd,
	spq_rsp_if.source rsp
);
	cmd_t q_cmd;
	logic q_valid, q_pop;

	spq_front u_front (.clk, .arst_n, .cmd, .q_cmd, .q_valid, .q_pop);
	spq_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
		.clk, .arst_n, .q_cmd, .q_valid, .q_pop, .rsp);
endmodule
`default_nettype wire

// ===== rtl/core/spq_front.sv =====
// Command intake: field check and a two-entry queue toward the back end.
`default_nettype none
module spq_front import spq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	spq_cmd_if.sink   cmd,
	output cmd_t      q_cmd,
	output logic      q_valid,
	input  wire logic q_pop
);
	cmd_t       fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       c;
	logic       push;

	always_comb begin
		c.op = cmd.operation;
		c.ent.id = cmd.patient_id;
		c.ent.age = cmd.patient_age;
		c.ent.prio = cmd.priority_level;
		c.bad = (cmd.patient_id == 16'd0) || (cmd.patient_age < AGE_MIN) ||
			(cmd.patient_age > AGE_MAX) || (cmd.priority_level < PRIO_BEST) ||
			(cmd.priority_level > PRIO_WORST);
	end

	assign cmd.ready = (cnt_q != 2'd2);
	assign push = cmd.valid && cmd.ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push) else $error("queue overflow");
	a_no_under: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> cnt_q != 2'd0) else $error("queue underflow");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("bad count");
endmodule
`default_nettype wire

// ===== rtl/core/spq_back.sv =====
// Execution engine: per-class ring store, history ring, counters, result register.
`default_nettype none
module spq_back import spq_pkg::*; #(
	parameter int QUEUE_DEPTH   = QueueDepthDef,
	parameter int HISTORY_DEPTH = HistoryDepthDef
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  cmd_t      q_cmd,
	input  wire logic q_valid,
	output logic      q_pop,
	spq_rsp_if.source rsp
);
	localparam int QW = $clog2(QUEUE_DEPTH + 1);
	localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QS = QW + 1;
	localparam int HW = $clog2(HISTORY_DEPTH + 1);
	localparam int HA = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int HS = HW + 1;

	localparam logic [2:0] S_IDLE = 3'd0, S_EXEC = 3'd1, S_SRV = 3'd2, S_UND = 3'd3,
		S_SCAN = 3'd4, S_SCHK = 3'd5, S_DONE = 3'd6;

	// one ring per priority class; service order is class 1, then 2, then 3
	entry_t qmem [3][QUEUE_DEPTH];
	// history ring: oldest at hbase_q, htop_q entries
	entry_t hmem [HISTORY_DEPTH];

	logic [2:0]    state_q;
	cmd_t          cur_q;
	logic [QW-1:0] cnt_q [3];
	logic [QA-1:0] head_q [3];
	logic [HA-1:0] hbase_q;
	logic [HW-1:0] htop_q;
	logic [15:0]   reg_q, srv_q, und_q;
	logic [1:0]    cls_q;
	logic [QW-1:0] k_q;
	entry_t        qrd_q, hrd_q;
	rsp_t          rsp_q;
	logic          rvalid_q;
	logic [QW-1:0] total;
	logic          full;
	logic [1:0]    icls, ucls, scls;

	logic          qwe, hwe;
	logic [1:0]    qwc, qrc;
	logic [QA-1:0] qwa, qra;
	logic [HA-1:0] hwa, hra;
	entry_t        qwd, hwd;

	function automatic logic [QA-1:0] qwrap(input logic [QS-1:0] s);
		logic [QS-1:0] lim;
		lim = QS'(QUEUE_DEPTH);
		return QA'((s >= lim) ? s - lim : s);
	endfunction

	function automatic logic [HA-1:0] hwrap(input logic [HS-1:0] s);
		logic [HS-1:0] lim;
		lim = HS'(HISTORY_DEPTH);
		return HA'((s >= lim) ? s - lim : s);
	endfunction

	assign total = QW'({2'b00, cnt_q[0]} + {2'b00, cnt_q[1]} + {2'b00, cnt_q[2]});
	assign full = (total >= QW'(QUEUE_DEPTH));
	assign icls = cur_q.ent.prio - 2'd1;
	assign ucls = hrd_q.prio - 2'd1;
	assign scls = (cnt_q[0] != '0) ? 2'd0 : ((cnt_q[1] != '0) ? 2'd1 : 2'd2);

	assign q_pop = (state_q == S_IDLE) && q_valid && !rvalid_q;
	assign rsp.valid = rvalid_q;
	assign rsp.status = rsp_q.status;
	assign rsp.entry_id = rsp_q.ent.id;
	assign rsp.entry_age = rsp_q.ent.age;
	assign rsp.entry_priority = rsp_q.ent.prio;
	assign rsp.registered_count = rsp_q.registered;
	assign rsp.served_count = rsp_q.served;
	assign rsp.undone_count = rsp_q.undone;
	assign rsp.waiting_count = rsp_q.waiting;

	always_comb begin
		qwe = 1'b0;
		qwc = icls;
		qwa = qwrap(QS'(head_q[icls]) + QS'(cnt_q[icls]));
		qwd = cur_q.ent;
		qrc = cls_q;
		qra = qwrap(QS'(head_q[cls_q]) + QS'(k_q));
		hwe = 1'b0;
		hwa = hwrap(HS'(hbase_q) + HS'(htop_q));
		hwd = qrd_q;
		hra = (htop_q == '0) ? hbase_q : hwrap(HS'(hbase_q) + HS'(htop_q) - HS'(1));
		case (state_q)
			S_EXEC: begin
				if (cur_q.op == OP_INSERT && !cur_q.bad && !full) qwe = 1'b1;
				// head of the best nonempty class, used by a serve
				qrc = scls;
				qra = head_q[scls];
			end
			S_SRV: hwe = 1'b1;
			S_UND: begin
				qwe = 1'b1;
				qwc = ucls;
				qwa = qwrap(QS'(head_q[ucls]) + QS'(cnt_q[ucls]));
				qwd = hrd_q;
			end
			default: ;
		endcase
	end

	// memories: one write, one registered read each
	always_ff @(posedge clk) begin
		if (qwe) qmem[qwc][qwa] <= qwd;
		qrd_q <= qmem[qrc][qra];
		if (hwe) hmem[hwa] <= hwd;
		hrd_q <= hmem[hra];
	end

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int k = 0; k < 3; k++) begin
				cnt_q[k] <= '0;
				head_q[k] <= '0;
			end
			hbase_q <= '0;
			htop_q <= '0;
			reg_q <= '0; srv_q <= '0; und_q <= '0;
			cls_q <= '0;
			k_q <= '0;
			rsp_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE) rvalid_q <= 1'b1;
			else if (rsp.ready) rvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (q_pop) state_q <= S_EXEC;
				S_EXEC: begin
					rsp_q.ent <= '0;
					case (cur_q.op)
						OP_INSERT: begin
							state_q <= S_DONE;
							if (cur_q.bad) rsp_q.status <= ST_INVALID;
							else if (full) rsp_q.status <= ST_FULL;
							else begin
								rsp_q.status <= ST_OK;
								cnt_q[icls] <= cnt_q[icls] + QW'(1);
								if (reg_q != CNT_MAX) reg_q <= reg_q + 16'd1;
							end
						end
						OP_SERVE: begin
							if (total == '0) begin
								rsp_q.status <= ST_EMPTY;
								state_q <= S_DONE;
							end else begin
								rsp_q.status <= ST_OK;
								cls_q <= scls;
								state_q <= S_SRV;
							end
						end
						OP_UNDO: begin
							if (htop_q == '0) begin
								rsp_q.status <= ST_NOHIST;
								state_q <= S_DONE;
							end else if (full) begin
								rsp_q.status <= ST_FULL;
								state_q <= S_DONE;
							end else begin
								rsp_q.status <= ST_OK;
								htop_q <= htop_q - HW'(1);
								state_q <= S_UND;
							end
						end
						default: begin
							rsp_q.status <= ST_NOTFOUND;
							cls_q <= '0;
							k_q <= '0;
							state_q <= S_SCAN;
						end
					endcase
				end
				S_SRV: begin
					rsp_q.ent <= qrd_q;
					head_q[cls_q] <= qwrap(QS'(head_q[cls_q]) + QS'(1));
					cnt_q[cls_q] <= cnt_q[cls_q] - QW'(1);
					// full history: the new entry overwrites the oldest
					if (htop_q >= HW'(HISTORY_DEPTH)) hbase_q <= hwrap(HS'(hbase_q) + HS'(1));
					else htop_q <= htop_q + HW'(1);
					if (srv_q != CNT_MAX) srv_q <= srv_q + 16'd1;
					state_q <= S_DONE;
				end
				S_UND: begin
					rsp_q.ent <= hrd_q;
					cnt_q[ucls] <= cnt_q[ucls] + QW'(1);
					if (srv_q != '0) srv_q <= srv_q - 16'd1;
					if (und_q != CNT_MAX) und_q <= und_q + 16'd1;
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (k_q < cnt_q[cls_q]) state_q <= S_SCHK;
					else if (cls_q == 2'd2) state_q <= S_DONE;
					else begin
						cls_q <= cls_q + 2'd1;
						k_q <= '0;
					end
				end
				S_SCHK: begin
					if (qrd_q.id == cur_q.ent.id) begin
						rsp_q.status <= ST_OK;
						rsp_q.ent <= qrd_q;
						state_q <= S_DONE;
					end else begin
						k_q <= k_q + QW'(1);
						state_q <= S_SCAN;
					end
				end
				S_DONE: begin
					rsp_q.registered <= reg_q;
					rsp_q.served <= srv_q;
					rsp_q.undone <= und_q;
					rsp_q.waiting <= 7'(total);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == S_IDLE) else $error("pop while busy");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		total <= QW'(QUEUE_DEPTH)) else $error("queue overfilled");
	a_hist: assert property (@(posedge clk) disable iff (!arst_n)
		htop_q <= HW'(HISTORY_DEPTH)) else $error("history overfilled");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rvalid_q && !rsp.ready |=> rvalid_q && $stable(rsp_q)) else $error("result dropped");
	a_rsp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rvalid_q |-> state_q == S_IDLE) else $error("busy with result pending");
endmodule
`default_nettype wire

// ===== bench/tb_spq_if_note.sv =====
// Scoreboard package for the testbench.
package tb_spq_sb_pkg;
	import spq_pkg::*;

	class queue_scoreboard;
		rsp_t pending[$];
		entry_t waiting[$];
		entry_t served_log[$];
		int unsigned registered, served, undone;
		int errors;
		int reported;

		function new();
			registered = 0;
			served = 0;
			undone = 0;
			errors = 0;
			reported = 0;
		endfunction

		// position behind every entry of equal or better priority
		function void place(entry_t e);
			int pos;
			pos = 0;
			while (pos < waiting.size() && waiting[pos].prio <= e.prio)
				pos++;
			waiting.insert(pos, e);
		endfunction

		function void note_command(logic [1:0] op, logic [15:0] id, logic [7:0] age,
			logic [1:0] prio);
			rsp_t r;
			entry_t e;
			r = '0;
			r.status = ST_OK;
			case (op)
				OP_INSERT: begin
					if (id == 0 || age < AGE_MIN || age > AGE_MAX || prio == 0)
						r.status = ST_INVALID;
					else if (waiting.size() >= QueueDepthDef)
						r.status = ST_FULL;
					else begin
						e.id = id;
						e.age = age;
						e.prio = prio;
						place(e);
						if (registered < CNT_MAX) registered++;
					end
				end
				OP_SERVE: begin
					if (waiting.size() == 0)
						r.status = ST_EMPTY;
					else begin
						r.ent = waiting.pop_front();
						if (served_log.size() >= HistoryDepthDef) void'(served_log.pop_front());
						served_log.push_back(r.ent);
						if (served < CNT_MAX) served++;
					end
				end
				OP_UNDO: begin
					if (served_log.size() == 0)
						r.status = ST_NOHIST;
					else if (waiting.size() >= QueueDepthDef)
						r.status = ST_FULL;
					else begin
						r.ent = served_log.pop_back();
						place(r.ent);
						if (served > 0) served--;
						if (undone < CNT_MAX) undone++;
					end
				end
				default: begin
					r.status = ST_NOTFOUND;
					foreach (waiting[i]) begin
						if (waiting[i].id == id) begin
							r.ent = waiting[i];
							r.status = ST_OK;
							break;
						end
					end
				end
			endcase
			r.registered = 16'(registered);
			r.served = 16'(served);
			r.undone = 16'(undone);
			r.waiting = 7'(waiting.size());
			pending.push_back(r);
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("unexpected result transaction %p", got);
				end
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("result mismatch: expected %p got %p", want, got);
				end
			end
		endfunction
	endclass
endpackage

// ===== bench/tb_stable_priority_queue_with_undo_top.sv =====
// Testbench top: random and directed commands against the priority queue with undo.
module tb_stable_priority_queue_with_undo_top import spq_pkg::*, tb_spq_sb_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LongStall = 200;

	logic clk;
	logic arst_n;
	spq_cmd_if cmd();
	spq_rsp_if rsp();

	queue_scoreboard board = new();
	bit calm;        // no idling in the last part
	bit long_done;   // receiver long stall already taken
	int nresults;
	int sent_ids[$];

	stable_priority_queue_with_undo_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.rsp(rsp)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic rsp_t sample_rsp();
		rsp_t r;
		r.status = rsp.status;
		r.ent.id = rsp.entry_id;
		r.ent.age = rsp.entry_age;
		r.ent.prio = rsp.entry_priority;
		r.registered = rsp.registered_count;
		r.served = rsp.served_count;
		r.undone = rsp.undone_count;
		r.waiting = rsp.waiting_count;
		return r;
	endfunction

	// offers one command and returns at the edge of its transaction
	task automatic send_cmd(logic [1:0] op, logic [15:0] id, logic [7:0] age,
		logic [1:0] prio);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = int'($urandom_range(1, 5));
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.operation <= op;
		cmd.patient_id <= id;
		cmd.patient_age <= age;
		cmd.priority_level <= prio;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		board.note_command(op, id, age, prio);
		if (op == OP_INSERT) sent_ids.push_back(int'(id));
	endtask

	task automatic send_random(int mix_undo);
		int pick;
		logic [15:0] id;
		logic [7:0] age;
		logic [1:0] prio;
		pick = int'($urandom_range(0, 99));
		id = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 40));
		age = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 150));
		prio = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'($urandom_range(1, 3));
		if (pick < 40)
			send_cmd(OP_INSERT, id, age, prio);
		else if (pick < 65)
			send_cmd(OP_SERVE, id, age, prio);
		else if (pick < 65 + mix_undo)
			send_cmd(OP_UNDO, id, age, prio);
		else begin
			if (sent_ids.size() > 0 && $urandom_range(0, 1) == 1)
				id = 16'(sent_ids[$urandom_range(0, sent_ids.size() - 1)]);
			send_cmd(OP_SEARCH, id, age, prio);
		end
	endtask

	task automatic wait_drained();
		cmd.valid <= 1'b0;
		do @(posedge clk); while (board.pending.size() != 0);
	endtask

	// receiver side
	initial begin
		int gap;
		rsp.ready = 1'b0;
		@(posedge clk iff arst_n === 1'b1);
		forever begin
			if (!long_done && nresults >= 250) begin
				long_done = 1'b1;
				rsp.ready <= 1'b0;
				repeat (LongStall) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				gap = int'($urandom_range(1, 5));
				rsp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			board.check_result(sample_rsp());
			nresults++;
		end
	end

	initial begin
		logic [1:0] prio;
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.operation = OP_INSERT;
		cmd.patient_id = '0;
		cmd.patient_age = '0;
		cmd.priority_level = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		repeat (280) send_random(15);

		// fill past the depth, then an undo while full
		for (int i = 0; i < QueueDepthDef + 4; i++) begin
			prio = 2'(i % 3 + 1);
			send_cmd(OP_INSERT, 16'(1000 + i), 8'd30, prio);
		end
		send_cmd(OP_SERVE, 16'd0, 8'd0, 2'd0);
		send_cmd(OP_INSERT, 16'd2000, 8'd150, 2'd3);
		send_cmd(OP_UNDO, 16'd0, 8'd0, 2'd0);
		wait_drained();

		// history overflow, searches, then undo past the history depth
		repeat (HistoryDepthDef + 4) send_cmd(OP_SERVE, 16'd0, 8'd0, 2'd0);
		send_cmd(OP_SEARCH, 16'd0, 8'd0, 2'd0);
		send_cmd(OP_SEARCH, 16'd1030, 8'd0, 2'd0);
		send_cmd(OP_SEARCH, 16'd2000, 8'd0, 2'd0);
		repeat (HistoryDepthDef + 4) send_cmd(OP_UNDO, 16'd0, 8'd0, 2'd0);

		// drain the queue and serve while empty
		while (board.waiting.size() != 0) send_cmd(OP_SERVE, 16'd0, 8'd0, 2'd0);
		send_cmd(OP_SERVE, 16'd0, 8'd0, 2'd0);
		send_cmd(OP_SERVE, 16'd0, 8'd0, 2'd0);

		// boundaries of the insert check
		send_cmd(OP_INSERT, 16'd0, 8'd20, 2'd1);
		send_cmd(OP_INSERT, 16'd5, 8'd0, 2'd1);
		send_cmd(OP_INSERT, 16'd5, 8'd151, 2'd1);
		send_cmd(OP_INSERT, 16'd5, 8'd20, 2'd0);
		send_cmd(OP_INSERT, 16'hFFFF, 8'd1, 2'd2);
		send_cmd(OP_SEARCH, 16'hFFFF, 8'd0, 2'd0);
		wait_drained();

		repeat (280) send_random(15);
		calm = 1'b1;
		repeat (150) send_random(15);
		wait_drained();
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end
endmodule
